/* hw/rtl/fvgm_pkg.sv */
// Shared types and constants for the FAT volume geometry mapper.
// Used by fvgm_csr, fvgm_geom, fvgm_pipe and fat_volume_geometry_mapper.
package fvgm_pkg;

   // register map, index = byte address / 4
   localparam int RegIdxW = 3;
   localparam int AddrW   = RegIdxW + 2;
   localparam int DataW   = 32;

   localparam logic [RegIdxW-1:0] REG_SECTORS_PER_CLUSTER = 3'd0;
   localparam logic [RegIdxW-1:0] REG_RESERVED_SECTORS    = 3'd1;
   localparam logic [RegIdxW-1:0] REG_FAT_COPIES          = 3'd2;
   localparam logic [RegIdxW-1:0] REG_ROOT_ENTRY_COUNT    = 3'd3;
   localparam logic [RegIdxW-1:0] REG_FAT_SIZE_SMALL      = 3'd4;
   localparam logic [RegIdxW-1:0] REG_FAT_SIZE_LARGE      = 3'd5;
   localparam logic [RegIdxW-1:0] REG_TOTAL_SECTORS_SMALL = 3'd6;
   localparam logic [RegIdxW-1:0] REG_TOTAL_SECTORS_LARGE = 3'd7;

   // FAT type codes
   localparam logic [1:0] KIND_FAT12 = 2'd0;
   localparam logic [1:0] KIND_FAT16 = 2'd1;
   localparam logic [1:0] KIND_FAT32 = 2'd2;

   // cluster count thresholds between FAT types
   localparam logic [31:0] FAT12_LIMIT = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT = 32'd65525;

   // bytes per root directory entry, as a shift
   localparam int DIR_ENTRY_SHIFT = 5;
   // first data cluster number
   localparam logic [31:0] FIRST_CLUSTER = 32'd2;

   // boot-record view with the active FAT size and total count picked
   typedef struct packed {
      logic [7:0]  spc;
      logic [15:0] rsvd;
      logic [7:0]  copies;
      logic [15:0] roots;
      logic [31:0] fat_size;
      logic [31:0] total;
   } cfg_type;

   // derived volume geometry, stable once ok is set until the next configuration write
   typedef struct packed {
      logic        ok;
      logic [1:0]  kind;
      logic [31:0] clusters;
      logic [31:0] root_start;
      logic [12:0] root_len;
      logic [31:0] data_start;
      logic [31:0] data_len;
   } geom_type;

endpackage

/* hw/rtl/fvgm_csr.sv */
// Configuration register file with an APB-style port.
// Depends on fvgm_pkg for the register map and cfg_type.
module fvgm_csr import fvgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [DataW-1:0] pwdata,
   output logic [DataW-1:0] prdata,
   output logic             pready,
   output cfg_type          cfg,
   output logic             cfg_wr
);

   logic [7:0]  spc_ff;
   logic [15:0] rsvd_ff;
   logic [7:0]  copies_ff;
   logic [15:0] roots_ff;
   logic [15:0] fsz_small_ff;
   logic [31:0] fsz_large_ff;
   logic [15:0] tot_small_ff;
   logic [31:0] tot_large_ff;
   logic [RegIdxW-1:0] idx;

   assign pready = 1'b1;
   assign idx    = paddr[AddrW-1:2];
   assign cfg_wr = psel && penable && pwrite && pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff       <= 8'd1;
         rsvd_ff      <= 16'd1;
         copies_ff    <= 8'd2;
         roots_ff     <= 16'd512;
         fsz_small_ff <= '0;
         fsz_large_ff <= '0;
         tot_small_ff <= '0;
         tot_large_ff <= '0;
      end else if (cfg_wr) begin
         case (idx)
            REG_SECTORS_PER_CLUSTER: spc_ff       <= pwdata[7:0];
            REG_RESERVED_SECTORS:    rsvd_ff      <= pwdata[15:0];
            REG_FAT_COPIES:          copies_ff    <= pwdata[7:0];
            REG_ROOT_ENTRY_COUNT:    roots_ff     <= pwdata[15:0];
            REG_FAT_SIZE_SMALL:      fsz_small_ff <= pwdata[15:0];
            REG_FAT_SIZE_LARGE:      fsz_large_ff <= pwdata;
            REG_TOTAL_SECTORS_SMALL: tot_small_ff <= pwdata[15:0];
            REG_TOTAL_SECTORS_LARGE: tot_large_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_SECTORS_PER_CLUSTER: prdata = {24'd0, spc_ff};
         REG_RESERVED_SECTORS:    prdata = {16'd0, rsvd_ff};
         REG_FAT_COPIES:          prdata = {24'd0, copies_ff};
         REG_ROOT_ENTRY_COUNT:    prdata = {16'd0, roots_ff};
         REG_FAT_SIZE_SMALL:      prdata = {16'd0, fsz_small_ff};
         REG_FAT_SIZE_LARGE:      prdata = fsz_large_ff;
         REG_TOTAL_SECTORS_SMALL: prdata = {16'd0, tot_small_ff};
         REG_TOTAL_SECTORS_LARGE: prdata = tot_large_ff;
         default:                 prdata = '0;
      endcase
   end

   // small fields win when nonzero
   always_comb begin
      cfg.spc      = spc_ff;
      cfg.rsvd     = rsvd_ff;
      cfg.copies   = copies_ff;
      cfg.roots    = roots_ff;
      cfg.fat_size = (fsz_small_ff != '0) ? {16'd0, fsz_small_ff} : fsz_large_ff;
      cfg.total    = (tot_small_ff != '0) ? {16'd0, tot_small_ff} : tot_large_ff;
   end

endmodule

/* hw/rtl/fvgm_geom.sv */
// Geometry sequencer: derives volume layout and cluster count after each
// configuration change, with a bit-serial divider. Depends on fvgm_pkg.
module fvgm_geom import fvgm_pkg::*; #(
   parameter int SECTOR_BYTES = 512
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     cfg_wr,
   output geom_type geom
);

   localparam int SecShift = $clog2(SECTOR_BYTES);
   localparam int RootW    = 16 + DIR_ENTRY_SHIFT + 1;

   typedef enum logic [2:0] {
      ST_MUL, ST_AREA, ST_OVER, ST_LEN, ST_DIV, ST_KIND, ST_DONE
   } state_type;

   state_type   state_ff;
   logic        ok_ff;
   logic [39:0] prod_ff;
   logic [40:0] area_ff;
   logic [41:0] over_ff;
   logic [12:0] root_len_ff;
   logic [31:0] data_len_ff;
   logic [7:0]  rem_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [1:0]  kind_ff;

   logic [RootW-1:0] root_bytes;
   logic [8:0]       rem_cat;
   logic             q_bit;
   logic [8:0]       rem_sub;
   logic [42:0]      total_ext;

   // root directory bytes, rounded up to whole sectors
   assign root_bytes = RootW'({cfg.roots, {DIR_ENTRY_SHIFT{1'b0}}})
                     + RootW'(SECTOR_BYTES - 1);

   // one restoring divide step
   assign rem_cat = {rem_ff, quo_ff[31]};
   assign q_bit   = (rem_cat >= {1'b0, cfg.spc});
   assign rem_sub = rem_cat - {1'b0, cfg.spc};

   assign total_ext = {11'd0, cfg.total};

   // sequencer and geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MUL;
         ok_ff    <= 1'b0;
      end else if (cfg_wr) begin
         state_ff <= ST_MUL;
         ok_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_MUL: begin
               prod_ff     <= 40'(cfg.copies) * 40'(cfg.fat_size);
               root_len_ff <= 13'(root_bytes >> SecShift);
               state_ff    <= ST_AREA;
            end
            ST_AREA: begin
               area_ff  <= 41'(cfg.rsvd) + 41'(prod_ff);
               state_ff <= ST_OVER;
            end
            ST_OVER: begin
               over_ff  <= 42'(area_ff) + 42'(root_len_ff);
               state_ff <= ST_LEN;
            end
            ST_LEN: begin
               if (total_ext > 43'(over_ff)) begin
                  data_len_ff <= cfg.total - over_ff[31:0];
                  quo_ff      <= cfg.total - over_ff[31:0];
               end else begin
                  data_len_ff <= '0;
                  quo_ff      <= '0;
               end
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // zero divisor always subtracts, leaving an all-ones quotient
               rem_ff <= q_bit ? rem_sub[7:0] : rem_cat[7:0];
               quo_ff <= {quo_ff[30:0], q_bit};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= ST_KIND;
               end
            end
            ST_KIND: begin
               if (quo_ff < FAT12_LIMIT) begin
                  kind_ff <= KIND_FAT12;
               end else if (quo_ff < FAT16_LIMIT) begin
                  kind_ff <= KIND_FAT16;
               end else begin
                  kind_ff <= KIND_FAT32;
               end
               ok_ff    <= 1'b1;
               state_ff <= ST_DONE;
            end
            ST_DONE: state_ff <= ST_DONE;
            default: state_ff <= ST_MUL;
         endcase
      end
   end

   always_comb begin
      geom.ok         = ok_ff;
      geom.kind       = kind_ff;
      geom.clusters   = quo_ff;
      geom.root_start = area_ff[31:0];
      geom.root_len   = root_len_ff;
      geom.data_start = over_ff[31:0];
      geom.data_len   = data_len_ff;
   end

endmodule

/* hw/rtl/fvgm_pipe.sv */
// Three-stage cluster lookup pipeline: cluster sector and FAT entry place.
// Depends on fvgm_pkg for cfg_type, geom_type and the FAT type codes.
module fvgm_pipe import fvgm_pkg::*; #(
   parameter int SECTOR_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  geom_type    geom,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] in_cluster,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_cluster_sector,
   output logic [31:0] out_entry_sector,
   output logic [11:0] out_entry_offset
);

   localparam int SecShift = $clog2(SECTOR_BYTES);

   logic        v1_ff, v2_ff, v3_ff;
   logic        en1, en2, en3;
   logic [31:0] nm2_ff;
   logic [33:0] ent_ff;
   logic [31:0] prod_ff;
   logic [31:0] esec2_ff;
   logic [11:0] eofs2_ff;
   logic [31:0] csec_ff;
   logic [31:0] esec3_ff;
   logic [11:0] eofs3_ff;

   logic [33:0] n_ext;
   logic [33:0] ent_in;
   logic [39:0] prod_in;
   logic [33:0] esec_in;

   // stage enables: a stage loads when empty or when its beat moves on
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = geom.ok && en1;

   // entry byte offset by FAT type
   assign n_ext = {2'd0, in_cluster};
   always_comb begin
      case (geom.kind)
         KIND_FAT12: ent_in = n_ext + (n_ext >> 1);
         KIND_FAT16: ent_in = n_ext << 1;
         default:    ent_in = n_ext << 2;
      endcase
   end

   assign prod_in = 40'(nm2_ff) * 40'(cfg.spc);
   assign esec_in = 34'(cfg.rsvd) + (ent_ff >> SecShift);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid && in_ready;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage 1: cluster offset and entry byte offset
   always_ff @(posedge clock) begin
      if (en1) begin
         nm2_ff <= in_cluster - FIRST_CLUSTER;
         ent_ff <= ent_in;
      end
   end

   // stage 2: cluster multiply, entry sector split
   always_ff @(posedge clock) begin
      if (en2) begin
         prod_ff  <= prod_in[31:0];
         esec2_ff <= esec_in[31:0];
         eofs2_ff <= 12'(ent_ff & 34'(SECTOR_BYTES - 1));
      end
   end

   // stage 3: output beat
   always_ff @(posedge clock) begin
      if (en3) begin
         csec_ff  <= prod_ff + geom.data_start;
         esec3_ff <= esec2_ff;
         eofs3_ff <= eofs2_ff;
      end
   end

   assign out_valid          = v3_ff;
   assign out_cluster_sector = csec_ff;
   assign out_entry_sector   = esec3_ff;
   assign out_entry_offset   = eofs3_ff;

endmodule

/* hw/rtl/fat_volume_geometry_mapper.sv */
// FAT volume geometry mapper, top level.
// Depends on fvgm_pkg, fvgm_csr, fvgm_geom and fvgm_pipe.
//
// Boot-record fields are written over the APB-style port (register i at
// byte address 4*i). Each req_ beat carries a cluster number; each rsp_
// beat returns the volume geometry together with that cluster's first
// sector and the sector and byte offset of its FAT entry.
// Each accepted req_ beat passes the three-stage lookup pipeline to
// rsp_valid; one beat can enter every cycle while rsp_ready is high.
// After reset and after every register write the geometry sequencer runs
// through its steps (multiply, sums, 32-step cluster count divide, type
// decode); req_ready stays low until it finishes.
// When the receiver holds rsp_ready low the pipeline fills up to three
// beats and then drops req_ready; nothing is lost or repeated.
// SECTOR_BYTES must be a power of two.
module fat_volume_geometry_mapper import fvgm_pkg::*; #(
   parameter int SECTOR_BYTES = 512
) (
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [DataW-1:0] pwdata,
   output logic [DataW-1:0] prdata,
   output logic             pready,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [15:0]      req_cluster_high,
   input  logic [15:0]      req_cluster_low,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_fat_kind,
   output logic [31:0]      rsp_cluster_total,
   output logic [31:0]      rsp_root_dir_start,
   output logic [12:0]      rsp_root_dir_length,
   output logic [31:0]      rsp_data_region_start,
   output logic [31:0]      rsp_data_region_length,
   output logic [31:0]      rsp_cluster_sector,
   output logic [31:0]      rsp_fat_entry_sector,
   output logic [11:0]      rsp_fat_entry_offset
);

   cfg_type  cfg;
   geom_type geom;
   logic     cfg_wr;

   // register file
   fvgm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .cfg_wr  (cfg_wr)
   );

   // volume geometry
   fvgm_geom #(.SECTOR_BYTES(SECTOR_BYTES)) u_geom (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cfg_wr (cfg_wr),
      .geom   (geom)
   );

   // per-beat lookup
   fvgm_pipe #(.SECTOR_BYTES(SECTOR_BYTES)) u_pipe (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .geom               (geom),
      .in_valid           (req_valid),
      .in_ready           (req_ready),
      .in_cluster         ({req_cluster_high, req_cluster_low}),
      .out_valid          (rsp_valid),
      .out_ready          (rsp_ready),
      .out_cluster_sector (rsp_cluster_sector),
      .out_entry_sector   (rsp_fat_entry_sector),
      .out_entry_offset   (rsp_fat_entry_offset)
   );

   // user keeps geometry still while beats are in flight; the block does not enforce it
   assign rsp_fat_kind           = geom.kind;
   assign rsp_cluster_total      = geom.clusters;
   assign rsp_root_dir_start     = geom.root_start;
   assign rsp_root_dir_length    = geom.root_len;
   assign rsp_data_region_start  = geom.data_start;
   assign rsp_data_region_length = geom.data_len;

endmodule
